>>> rtl/ppu_cpu_register_port_defines.svh
// Assertion macros shared by the register port checker.
// No dependencies; include by bare file name.
`ifndef PPU_CPU_REGISTER_PORT_DEFINES_SVH
`define PPU_CPU_REGISTER_PORT_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define PPU_CRP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form: when cond holds, check must hold in the same cycle.
`define PPU_CRP_ASSERT_IMP(label, cond, check, msg) \
	`PPU_CRP_ASSERT(label, (cond) |-> (check), msg)

`endif

>>> rtl/ppu_crp_pkg.sv
// Package for the picture processor CPU register port.
// Holds function codes, register addresses and reset constants; no dependencies.
package ppu_crp_pkg;

	// Function selector codes
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_WARM  = 2'd2;
	localparam logic [1:0] FUNC_IDLE  = 2'd3;

	// Register addresses
	localparam logic [15:0] ADDR_CTRL     = 16'h2000;
	localparam logic [15:0] ADDR_MASK     = 16'h2001;
	localparam logic [15:0] ADDR_STATUS   = 16'h2002;
	localparam logic [15:0] ADDR_OAM_ADDR = 16'h2003;
	localparam logic [15:0] ADDR_OAM_DATA = 16'h2004;
	localparam logic [15:0] ADDR_SCROLL   = 16'h2005;
	localparam logic [15:0] ADDR_VRAM_PTR = 16'h2006;
	localparam logic [15:0] ADDR_VRAM_DAT = 16'h2007;

	// Status and pointer constants
	localparam logic [7:0]  STATUS_RESET  = 8'ha0;
	localparam logic [7:0]  STATUS_VBLANK = 8'h80;
	localparam logic [15:0] VRAM_STEP_ROW = 16'h0020;
	localparam logic [15:0] VRAM_STEP_COL = 16'h0001;
	localparam int unsigned CTRL_INC_BIT  = 2;

endpackage

>>> rtl/ppu_crp_if.sv
// Valid/ready channel interfaces for the register port request and response words.
// No dependencies.

// Request word: one bus access or warm reset
interface ppu_crp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] bus_address;
	logic [7:0]  write_data;

	modport source (output valid, output func, output bus_address, output write_data,
		input ready);
	modport sink (input valid, input func, input bus_address, input write_data,
		output ready);
endinterface

// Response word: read byte, VRAM pointer and write toggle after the access
interface ppu_crp_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [15:0] vram_pointer;
	logic        toggle_now;

	modport source (output valid, output read_data, output vram_pointer, output toggle_now,
		input ready);
	modport sink (input valid, input read_data, input vram_pointer, input toggle_now,
		output ready);
endinterface

>>> rtl/ppu_cpu_register_port.sv
// Pipeline: a word accepted into the input register moves on into the response register.
// Throughput: one word per cycle; the input register advances whenever the
// response register is empty or being taken, so only response backpressure stalls.
// Reset (arst_n low, asynchronous): registers take their power-on values, status
// reads 0xa0, and both pipeline valids clear.
// Uses ppu_crp_pkg and the interfaces in ppu_crp_if.sv.
module ppu_cpu_register_port (
	input logic           clk,
	input logic           arst_n,
	ppu_crp_req_if.sink   req,
	ppu_crp_rsp_if.source rsp
);

	// Input register
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;

	// Architectural registers
	logic [7:0]  control_q;
	logic [7:0]  mask_q;
	logic [7:0]  status_q;
	logic [7:0]  oam_ptr_q;
	logic [7:0]  oam_byte_q;
	logic [7:0]  scroll_q;
	logic [15:0] vram_addr_q;
	logic [7:0]  data_byte_q;
	logic        toggle_q;
	logic [7:0]  open_bus_q;

	// Next values
	logic [7:0]  control_d;
	logic [7:0]  mask_d;
	logic [7:0]  status_d;
	logic [7:0]  oam_ptr_d;
	logic [7:0]  oam_byte_d;
	logic [7:0]  scroll_d;
	logic [15:0] vram_addr_d;
	logic [7:0]  data_byte_d;
	logic        toggle_d;
	logic [7:0]  open_bus_d;
	logic [7:0]  rdata_d;

	// Response register
	logic        out_valid_q;
	logic [7:0]  rdata_q;
	logic [15:0] vptr_q;
	logic        tog_q;

	logic advance;

	// Move the input word on when the response register frees up
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Capture the request word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1  <= req.func;
			addr_s1  <= req.bus_address;
			wdata_s1 <= req.write_data;
		end
	end

	// Decode the access and compute register updates
	always_comb begin
		control_d   = control_q;
		mask_d      = mask_q;
		status_d    = status_q;
		oam_ptr_d   = oam_ptr_q;
		oam_byte_d  = oam_byte_q;
		scroll_d    = scroll_q;
		vram_addr_d = vram_addr_q;
		data_byte_d = data_byte_q;
		toggle_d    = toggle_q;
		open_bus_d  = open_bus_q;
		rdata_d     = 8'h00;
		unique case (func_s1)
			ppu_crp_pkg::FUNC_READ: begin
				unique case (addr_s1)
					ppu_crp_pkg::ADDR_STATUS: begin
						rdata_d  = status_q;
						status_d = status_q & ~ppu_crp_pkg::STATUS_VBLANK;
						toggle_d = 1'b0;
					end
					ppu_crp_pkg::ADDR_OAM_DATA: rdata_d = oam_byte_q;
					ppu_crp_pkg::ADDR_VRAM_DAT: rdata_d = data_byte_q;
					default:                    rdata_d = open_bus_q;
				endcase
			end
			ppu_crp_pkg::FUNC_WRITE: begin
				open_bus_d = wdata_s1;
				unique case (addr_s1)
					ppu_crp_pkg::ADDR_CTRL: begin
						control_d = wdata_s1;
						toggle_d  = 1'b0;
					end
					ppu_crp_pkg::ADDR_MASK:     mask_d = wdata_s1;
					ppu_crp_pkg::ADDR_OAM_ADDR: oam_ptr_d = wdata_s1;
					ppu_crp_pkg::ADDR_OAM_DATA: begin
						oam_byte_d = wdata_s1;
						oam_ptr_d  = oam_ptr_q + 8'd1;
					end
					ppu_crp_pkg::ADDR_SCROLL: begin
						scroll_d = wdata_s1;
						toggle_d = !toggle_q;
					end
					ppu_crp_pkg::ADDR_VRAM_PTR: begin
						// First write loads the high byte, second the low byte
						if (toggle_q) begin
							vram_addr_d = {vram_addr_q[15:8], wdata_s1};
						end else begin
							vram_addr_d = {wdata_s1, vram_addr_q[7:0]};
						end
						toggle_d = !toggle_q;
					end
					ppu_crp_pkg::ADDR_VRAM_DAT: begin
						data_byte_d = wdata_s1;
						if (control_q[ppu_crp_pkg::CTRL_INC_BIT]) begin
							vram_addr_d = vram_addr_q + ppu_crp_pkg::VRAM_STEP_ROW;
						end else begin
							vram_addr_d = vram_addr_q + ppu_crp_pkg::VRAM_STEP_COL;
						end
					end
					default: ;
				endcase
			end
			ppu_crp_pkg::FUNC_WARM: begin
				control_d   = 8'h00;
				mask_d      = 8'h00;
				status_d    = status_q | ppu_crp_pkg::STATUS_VBLANK;
				scroll_d    = 8'h00;
				data_byte_d = 8'h00;
			end
			default: ;
		endcase
	end

	// Commit register updates as the word advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q   <= 8'h00;
			mask_q      <= 8'h00;
			status_q    <= ppu_crp_pkg::STATUS_RESET;
			oam_ptr_q   <= 8'h00;
			oam_byte_q  <= 8'h00;
			scroll_q    <= 8'h00;
			vram_addr_q <= 16'h0000;
			data_byte_q <= 8'h00;
			toggle_q    <= 1'b0;
			open_bus_q  <= 8'h00;
		end else if (advance) begin
			control_q   <= control_d;
			mask_q      <= mask_d;
			status_q    <= status_d;
			oam_ptr_q   <= oam_ptr_d;
			oam_byte_q  <= oam_byte_d;
			scroll_q    <= scroll_d;
			vram_addr_q <= vram_addr_d;
			data_byte_q <= data_byte_d;
			toggle_q    <= toggle_d;
			open_bus_q  <= open_bus_d;
		end
	end

	// Hold the response word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q <= rdata_d;
			vptr_q  <= vram_addr_d;
			tog_q   <= toggle_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_data    = rdata_q;
	assign rsp.vram_pointer = vptr_q;
	assign rsp.toggle_now   = tog_q;

endmodule

>>> rtl/ppu_crp_checker.sv
// Port-level checker for ppu_cpu_register_port, bound into that module.
// Uses ppu_crp_pkg and the macros in ppu_cpu_register_port_defines.svh.
`include "ppu_cpu_register_port_defines.svh"

module ppu_crp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_func,
	input logic [15:0] req_bus_address,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [7:0]  rsp_read_data,
	input logic [15:0] rsp_vram_pointer,
	input logic        rsp_toggle_now
);

	// A stalled response word keeps its payload
	`PPU_CRP_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data) && $stable(rsp_vram_pointer) && $stable(rsp_toggle_now)), "response word changed while stalled")

	// A response appearing from empty stems from an accepted request word
	`PPU_CRP_ASSERT_IMP(a_rsp_origin, $rose(rsp_valid), $past(req_valid && req_ready, 2), "response without accepted request")

	// A status read always leaves the write toggle cleared
	`PPU_CRP_ASSERT_IMP(a_status_toggle, $rose(rsp_valid) && $past(req_func == ppu_crp_pkg::FUNC_READ && req_bus_address == ppu_crp_pkg::ADDR_STATUS, 2), !rsp_toggle_now, "toggle set after status read")

	// Input is never refused while the output side is free
	`PPU_CRP_ASSERT_IMP(a_no_idle_stall, !rsp_valid, req_ready, "request stalled with empty output")

endmodule

bind ppu_cpu_register_port ppu_crp_checker u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_func         (req.func),
	.req_bus_address  (req.bus_address),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_read_data    (rsp.read_data),
	.rsp_vram_pointer (rsp.vram_pointer),
	.rsp_toggle_now   (rsp.toggle_now)
);

>>> tb/ppu_cpu_register_port_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the picture processor CPU register port.
// Depends on ppu_crp_pkg, the channel interfaces in ppu_crp_if.sv and the port RTL.
module ppu_cpu_register_port_tb;

	// One response word as the port should present it
	typedef struct packed {
		logic [7:0]  rd;
		logic [15:0] vptr;
		logic        tog;
	} port_rsp_t;

	logic clk;
	logic arst_n;

	ppu_crp_req_if req_ch();
	ppu_crp_rsp_if rsp_ch();

	ppu_cpu_register_port u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Register file as the CPU should see it
	logic [7:0]  ctrl_m;
	logic [7:0]  mask_m;
	logic [7:0]  status_m;
	logic [7:0]  oam_ptr_m;
	logic [7:0]  oam_data_m;
	logic [7:0]  scroll_m;
	logic [15:0] vaddr_m;
	logic [7:0]  vdata_m;
	logic        toggle_m;
	logic [7:0]  bus_latch_m;

	port_rsp_t rsp_expected_q[$];
	int        mismatches;
	int        words_sent;
	bit        gapless_req;
	bit        gapless_rsp;
	int        stall_left;

	// Clock and reset
	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#(5_000_000);
		$display("ppu_cpu_register_port_tb: FAIL");
		$finish;
	end

	// Random idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Random byte and address for stimulus
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] rand_addr();
		return 16'($urandom_range(0, 65535));
	endfunction

	// Apply one access to the register file and return the response word it causes
	function automatic port_rsp_t predict_access(logic [1:0] f, logic [15:0] a, logic [7:0] d);
		port_rsp_t r;
		r.rd = 8'h00;
		unique case (f)
			ppu_crp_pkg::FUNC_READ: begin
				unique case (a)
					ppu_crp_pkg::ADDR_STATUS: begin
						r.rd = status_m;
						status_m = status_m & ~ppu_crp_pkg::STATUS_VBLANK;
						toggle_m = 1'b0;
					end
					ppu_crp_pkg::ADDR_OAM_DATA: r.rd = oam_data_m;
					ppu_crp_pkg::ADDR_VRAM_DAT: r.rd = vdata_m;
					default: r.rd = bus_latch_m;
				endcase
			end
			ppu_crp_pkg::FUNC_WRITE: begin
				bus_latch_m = d;
				unique case (a)
					ppu_crp_pkg::ADDR_CTRL: begin
						ctrl_m = d;
						toggle_m = 1'b0;
					end
					ppu_crp_pkg::ADDR_MASK: mask_m = d;
					ppu_crp_pkg::ADDR_OAM_ADDR: oam_ptr_m = d;
					ppu_crp_pkg::ADDR_OAM_DATA: begin
						oam_data_m = d;
						oam_ptr_m = oam_ptr_m + 8'd1;
					end
					ppu_crp_pkg::ADDR_SCROLL: begin
						scroll_m = d;
						toggle_m = ~toggle_m;
					end
					ppu_crp_pkg::ADDR_VRAM_PTR: begin
						if (toggle_m)
							vaddr_m[7:0] = d;
						else
							vaddr_m[15:8] = d;
						toggle_m = ~toggle_m;
					end
					ppu_crp_pkg::ADDR_VRAM_DAT: begin
						vdata_m = d;
						if (ctrl_m[ppu_crp_pkg::CTRL_INC_BIT])
							vaddr_m = vaddr_m + ppu_crp_pkg::VRAM_STEP_ROW;
						else
							vaddr_m = vaddr_m + ppu_crp_pkg::VRAM_STEP_COL;
					end
					default: ;
				endcase
			end
			ppu_crp_pkg::FUNC_WARM: begin
				ctrl_m = 8'h00;
				mask_m = 8'h00;
				status_m = status_m | ppu_crp_pkg::STATUS_VBLANK;
				scroll_m = 8'h00;
				vdata_m = 8'h00;
			end
			default: ;
		endcase
		r.vptr = vaddr_m;
		r.tog = toggle_m;
		return r;
	endfunction

	// Offer one request word, hold it until taken, then record its response
	task automatic send_word(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d);
		int gap;
		gap = gapless_req ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.bus_address <= a;
		req_ch.write_data <= d;
		do @(posedge clk); while (!req_ch.ready);
		rsp_expected_q.push_back(predict_access(f, a, d));
		words_sent++;
	endtask

	function automatic void note_mismatch(string fld, logic [15:0] exp_v, logic [15:0] act_v);
		if (mismatches < 10)
			$display("mismatch on %s: expected %h, got %h at %0t",
				fld, exp_v, act_v, $realtime);
		mismatches++;
	endfunction

	// Response side: random backpressure and field-by-field compare
	always @(posedge clk) begin
		port_rsp_t exp_w;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("response word with none expected at %0t", $realtime);
					mismatches++;
				end else begin
					exp_w = rsp_expected_q.pop_front();
					if (rsp_ch.read_data !== exp_w.rd)
						note_mismatch("read_data", 16'(exp_w.rd), 16'(rsp_ch.read_data));
					if (rsp_ch.vram_pointer !== exp_w.vptr)
						note_mismatch("vram_pointer", exp_w.vptr, rsp_ch.vram_pointer);
					if (rsp_ch.toggle_now !== exp_w.tog)
						note_mismatch("toggle_now", 16'(exp_w.tog), 16'(rsp_ch.toggle_now));
				end
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!gapless_rsp && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left <= pick_gap();
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_power_on_reads();
		send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_STATUS, 8'h00);
		send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_STATUS, 8'hff);
		send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_OAM_DATA, 8'h00);
		send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_VRAM_DAT, 8'h00);
		send_word(ppu_crp_pkg::FUNC_READ, 16'h0000, 8'h00);
	endtask

	task automatic test_register_writes();
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_CTRL, 8'hff);
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_MASK, 8'hff);
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_OAM_ADDR, 8'hfe);
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_OAM_DATA, 8'ha5);
		// pointer wraps past 0xff
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_OAM_DATA, 8'h5a);
		send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_OAM_DATA, 8'h00);
		// status is read-only: only the open-bus latch moves
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_STATUS, 8'h77);
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_SCROLL, 8'h12);
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_SCROLL, 8'h34);
	endtask

	task automatic test_vram_pointer_steps();
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_VRAM_PTR, 8'hff);
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_VRAM_PTR, 8'hff);
		// row step with control bit 2 set, wrapping at 16 bits
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_VRAM_DAT, 8'h00);
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_CTRL, 8'h00);
		send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_VRAM_DAT, 8'hff);
		send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_VRAM_DAT, 8'h00);
	endtask

	task automatic test_warm_reset();
		send_word(ppu_crp_pkg::FUNC_WARM, ppu_crp_pkg::ADDR_CTRL, 8'hff);
		send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_STATUS, 8'h00);
	endtask

	task automatic test_unmapped_access();
		send_word(ppu_crp_pkg::FUNC_WRITE, 16'hffff, 8'h3c);
		send_word(ppu_crp_pkg::FUNC_READ, 16'hffff, 8'h00);
		send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_CTRL, 8'h00);
		send_word(ppu_crp_pkg::FUNC_IDLE, ppu_crp_pkg::ADDR_STATUS, 8'hff);
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int kind;
		int run_len;
		int k;
		stop_at = words_sent + 750;
		while (words_sent < stop_at) begin
			// switch idling on and off in stretches
			if ($urandom_range(0, 9) == 0) begin
				gapless_req = ($urandom_range(0, 2) == 0);
				gapless_rsp = ($urandom_range(0, 2) == 0);
			end
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				// pointer load then a run of data accesses
				if ($urandom_range(0, 1))
					send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_STATUS, rand_byte());
				send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_VRAM_PTR, rand_byte());
				send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_VRAM_PTR, rand_byte());
				run_len = $urandom_range(1, 6);
				for (k = 0; k < run_len; k++)
					send_word(($urandom_range(0, 3) == 0) ?
						ppu_crp_pkg::FUNC_READ : ppu_crp_pkg::FUNC_WRITE,
						ppu_crp_pkg::ADDR_VRAM_DAT, rand_byte());
			end else if (kind < 40) begin
				if ($urandom_range(0, 1))
					send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_STATUS, rand_byte());
				send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_SCROLL, rand_byte());
				send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_SCROLL, rand_byte());
			end else if (kind < 48) begin
				send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_OAM_ADDR, rand_byte());
				run_len = $urandom_range(1, 4);
				for (k = 0; k < run_len; k++)
					send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_OAM_DATA,
						rand_byte());
				send_word(ppu_crp_pkg::FUNC_READ, ppu_crp_pkg::ADDR_OAM_DATA, rand_byte());
			end else if (kind < 56) begin
				send_word(ppu_crp_pkg::FUNC_WRITE, ppu_crp_pkg::ADDR_CTRL, rand_byte());
			end else if (kind < 88) begin
				send_word($urandom_range(0, 1) ?
					ppu_crp_pkg::FUNC_READ : ppu_crp_pkg::FUNC_WRITE,
					ppu_crp_pkg::ADDR_CTRL + 16'($urandom_range(0, 7)), rand_byte());
			end else if (kind < 95) begin
				send_word($urandom_range(0, 1) ?
					ppu_crp_pkg::FUNC_READ : ppu_crp_pkg::FUNC_WRITE,
					rand_addr(), rand_byte());
			end else if (kind < 98) begin
				send_word(ppu_crp_pkg::FUNC_WARM, rand_addr(), rand_byte());
			end else begin
				send_word(ppu_crp_pkg::FUNC_IDLE, rand_addr(), rand_byte());
			end
		end
	endtask

	initial begin
		int drain;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func <= ppu_crp_pkg::FUNC_IDLE;
		req_ch.bus_address <= 16'h0000;
		req_ch.write_data <= 8'h00;
		mismatches = 0;
		words_sent = 0;
		gapless_req = 1'b0;
		gapless_rsp = 1'b0;
		ctrl_m = 8'h00;
		mask_m = 8'h00;
		status_m = ppu_crp_pkg::STATUS_RESET;
		oam_ptr_m = 8'h00;
		oam_data_m = 8'h00;
		scroll_m = 8'h00;
		vaddr_m = 16'h0000;
		vdata_m = 8'h00;
		toggle_m = 1'b0;
		bus_latch_m = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_reads();
		test_register_writes();
		test_vram_pointer_steps();
		test_warm_reset();
		test_unmapped_access();
		test_random_traffic();

		// drain outstanding responses, then let the pipeline settle
		req_ch.valid <= 1'b0;
		gapless_rsp = 1'b0;
		drain = 0;
		while (rsp_expected_q.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && rsp_expected_q.size() == 0)
			$display("ppu_cpu_register_port_tb: PASS");
		else
			$display("ppu_cpu_register_port_tb: FAIL");
		$finish;
	end

endmodule
